// ----- hdl/swept_point_segment_hit_unit_assert.svh -----
// Assertion macros used by the block's top module.
`ifndef SWEPT_POINT_SEGMENT_HIT_UNIT_ASSERT_SVH
`define SWEPT_POINT_SEGMENT_HIT_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SPSH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define SPSH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hdl/spsh_pkg.sv -----
// ----------------------------------------------------------------------------
// spsh_pkg
// Types, constants and codes shared by the swept point segment hit block.
// ----------------------------------------------------------------------------
package spsh_pkg;

  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int FRAC_BITS_DEF    = 16;

  // Request codes.
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_XX = 3'd0;
  localparam logic [2:0] CFG_XY = 3'd1;
  localparam logic [2:0] CFG_YX = 3'd2;
  localparam logic [2:0] CFG_YY = 3'd3;
  localparam logic [2:0] CFG_TX = 3'd4;
  localparam logic [2:0] CFG_TY = 3'd5;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] seg_a_x;
    logic signed [31:0] seg_a_y;
    logic signed [31:0] seg_b_x;
    logic signed [31:0] seg_b_y;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic               status;
  } rsp_t;

  // Operations of the shared multiply-accumulate unit.
  typedef enum logic [1:0] {
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_op_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic    en;
    mac_op_t op;
  } mac_ctl_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD,
    ST_RDW,
    ST_XF,
    ST_DIFF,
    ST_S,
    ST_T,
    ST_TEST,
    ST_DIV,
    ST_HX,
    ST_HY,
    ST_HXS,
    ST_D1,
    ST_D2,
    ST_NEXT,
    ST_RESP
  } state_t;

endpackage

// ----- hdl/spsh_ram.sv -----
// ----------------------------------------------------------------------------
// spsh_ram
// Generic simple dual port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module spsh_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/spsh_mac.sv -----
// ----------------------------------------------------------------------------
// spsh_mac
// Shared 33x34 signed multiplier with a registered 96 bit accumulator.
// ----------------------------------------------------------------------------
module spsh_mac import spsh_pkg::*; (
  input  logic               clk,
  input  mac_ctl_t           ctl,
  input  logic signed [32:0] op_a,
  input  logic signed [33:0] op_b,
  output logic signed [95:0] acc
);

  logic signed [66:0] prod;

  assign prod = op_a * op_b;

  // Load, add or subtract one product per cycle while ctl.en is set.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      unique case (ctl.op)
        MAC_LOAD: acc <= 96'(prod);
        MAC_ADD:  acc <= acc + 96'(prod);
        MAC_SUB:  acc <= acc - 96'(prod);
        default:  acc <= acc;
      endcase
    end
  end

endmodule

// ----- hdl/spsh_div.sv -----
// ----------------------------------------------------------------------------
// spsh_div
// Restoring fraction divider: floor(num * 2^FRAC_BITS / den), one bit a cycle.
// ----------------------------------------------------------------------------
module spsh_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [66:0]          num,
  input  logic [66:0]          den,
  output logic                 done,
  output logic [FRAC_BITS:0]   quot
);

  localparam int CW = $clog2(FRAC_BITS + 2);

  logic [67:0]   rem;
  logic [67:0]   dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          ge;

  assign ge = rem >= dvs;

  // One quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= {1'b0, num};
        dvs  <= {1'b0, den};
        quot <= '0;
      end else if (busy) begin
        quot <= {quot[FRAC_BITS-1:0], ge};
        rem  <= (ge ? rem - dvs : rem) << 1;
        if (cnt == CW'(FRAC_BITS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

// ----- hdl/swept_point_segment_hit_unit.sv -----
// Add, clear and unused codes offer their response the cycle after the request.
// A query walks the stored segments in order; a segment that fails the side test skips
// the bit-serial divider. The response is offered from ST_RD once the last segment is
// done with, or from ST_D2 as soon as a segment is hit.
// One request is handled at a time; the next is taken the cycle after the response leaves.
// Synchronous reset empties the segment table and loads the identity transform.
// ----------------------------------------------------------------------------
// swept_point_segment_hit_unit
// Swept point against segment table crossing test with an affine transform.
// ----------------------------------------------------------------------------
module swept_point_segment_hit_unit import spsh_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  `include "swept_point_segment_hit_unit_assert.svh"

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  // Configuration registers.
  logic signed [31:0] mat [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      mat[0] <= 32'sd1 <<< FRAC_BITS;
      mat[1] <= '0;
      mat[2] <= '0;
      mat[3] <= 32'sd1 <<< FRAC_BITS;
      mat[4] <= '0;
      mat[5] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_XX: mat[0] <= cfg_data;
        CFG_XY: mat[1] <= cfg_data;
        CFG_YX: mat[2] <= cfg_data;
        CFG_YY: mat[3] <= cfg_data;
        CFG_TX: mat[4] <= cfg_data;
        CFG_TY: mat[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Segment store.
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [127:0]  ram_rdata;
  logic [CW-1:0] count;

  spsh_ram #(.WIDTH(128), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata ({req.seg_a_x, req.seg_a_y, req.seg_b_x, req.seg_b_y}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared multiplier and divider.
  mac_ctl_t           mctl;
  logic signed [32:0] ma;
  logic signed [33:0] mb;
  logic signed [95:0] acc;

  spsh_mac u_mac (.clk(clk), .ctl(mctl), .op_a(ma), .op_b(mb), .acc(acc));

  logic               dstart;
  logic               ddone;
  logic [FRAC_BITS:0] dq;
  logic [66:0]        dnum;
  logic [66:0]        dden;

  spsh_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quot(dq)
  );

  // Working registers.
  state_t             state, state_next;
  logic [4:0]         step;
  logic [CW-1:0]      idx;
  req_t               q;
  logic signed [31:0] pt [4];   // transformed ax, ay, bx, by
  logic signed [32:0] dx, dy;
  logic signed [66:0] sv, tv;
  logic signed [31:0] hx, hy;
  logic signed [63:0] xfs;
  logic signed [31:0] xfv;

  // Floored second product plus floored first product plus translation, saturated.
  logic signed [95:0] xsum;
  always_comb begin
    xsum = (acc >>> FRAC_BITS) + 96'(xfs) + 96'(mat[{2'b10, step[0]}]);
    if (xsum > 96'sd2147483647) xfv = 32'h7fffffff;
    else if (xsum < -96'sd2147483648) xfv = 32'h80000000;
    else xfv = xsum[31:0];
  end

  logic signed [31:0] rx, ry;
  assign rx = step[1] ? ram_rdata[63:32] : ram_rdata[127:96];
  assign ry = step[1] ? ram_rdata[31:0]  : ram_rdata[95:64];

  logic signed [32:0] px, py;
  assign px = 33'(hx);
  assign py = 33'(hy);

  // Sequencer: next state and unit operands.
  always_comb begin
    state_next = state;
    mctl       = '{en: 1'b0, op: MAC_LOAD};
    ma         = '0;
    mb         = '0;
    dstart     = 1'b0;
    ram_we     = 1'b0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req.req_type == REQ_QUERY) state_next = ST_RD;
          else state_next = ST_RESP;
          ram_we = (req.req_type == REQ_ADD) && (count < CW'(MAX_SEGMENTS));
        end
      end
      ST_RD: state_next = (idx < count) ? ST_RDW : ST_RESP;
      ST_RDW: state_next = ST_XF;
      // step: bit1 picks endpoint, bit0 picks output axis, bit2 multiply phase.
      ST_XF: begin
        mctl.en = 1'b1;
        ma = step[2] ? 33'(mat[{1'b0, step[0], 1'b1}]) : 33'(mat[{1'b0, step[0], 1'b0}]);
        mb = step[2] ? 34'(ry) : 34'(rx);
        if (step[3] && step[1:0] == 2'd3) state_next = ST_DIFF;
      end
      ST_DIFF: state_next = ST_S;
      // s and t: dy*(px-ax) - dx*(py-ay).
      ST_S, ST_T: begin
        mctl.en = 1'b1;
        mctl.op = step[0] ? MAC_SUB : MAC_LOAD;
        ma = step[0] ? dx : dy;
        mb = step[0] ? 34'(((state == ST_S) ? 34'(q.start_y) : 34'(q.end_y)) - 34'(pt[1]))
                     : 34'(((state == ST_S) ? 34'(q.start_x) : 34'(q.end_x)) - 34'(pt[0]));
        if (step[1]) state_next = (state == ST_S) ? ST_T : ST_TEST;
      end
      ST_TEST: begin
        if (sv > 0 && tv <= 0) begin
          dstart = 1'b1;
          state_next = ST_DIV;
        end else state_next = ST_NEXT;
      end
      ST_DIV: if (ddone) state_next = ST_HX;
      ST_HX: begin
        mctl.en = 1'b1;
        ma = 33'(q.end_x) - 33'(q.start_x);
        mb = 34'(dq);
        state_next = ST_HY;
      end
      ST_HY: begin
        mctl.en = 1'b1;
        ma = 33'(q.end_y) - 33'(q.start_y);
        mb = 34'(dq);
        state_next = ST_HXS;
      end
      ST_HXS: state_next = ST_D1;
      // e.(H - A') and e.(H - B').
      ST_D1, ST_D2: begin
        mctl.en = 1'b1;
        mctl.op = step[0] ? MAC_ADD : MAC_LOAD;
        ma = step[0] ? dy : dx;
        mb = (state == ST_D1) ? (step[0] ? 34'(py) - 34'(pt[1]) : 34'(px) - 34'(pt[0]))
                              : (step[0] ? 34'(py) - 34'(pt[3]) : 34'(px) - 34'(pt[2]));
        if (step[1]) begin
          if (state == ST_D1) state_next = (acc < 0) ? ST_NEXT : ST_D2;
          else state_next = (acc > 0) ? ST_NEXT : ST_RESP;
        end
      end
      ST_NEXT: state_next = ST_RD;
      ST_RESP: if (rsp_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      step      <= '0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          step <= '0;
          idx  <= '0;
          if (req_valid) begin
            q   <= req;
            rsp <= '{hit: 1'b0, hit_x: '0, hit_y: '0,
                     status: (req.req_type == REQ_ADD) && (count >= CW'(MAX_SEGMENTS))};
            rsp_valid <= req.req_type != REQ_QUERY;
            if (req.req_type == REQ_ADD) begin
              if (count < CW'(MAX_SEGMENTS)) count <= count + 1'b1;
            end else if (req.req_type == REQ_CLEAR) begin
              count <= '0;
            end
          end
        end
        ST_RD: begin
          step <= '0;
          if (idx >= count) rsp_valid <= 1'b1;
        end
        ST_XF: begin
          // First product floored and kept, second product, then the sum is taken.
          if (step[3]) begin
            pt[step[1:0]] <= xfv;
            step <= {3'b000, step[1:0]} + 5'd1;
          end else if (step[2]) begin
            xfs  <= 64'(acc >>> FRAC_BITS);
            step <= step | 5'd8;
          end else begin
            step <= step | 5'd4;
          end
        end
        ST_DIFF: begin
          dx   <= 33'(pt[2]) - 33'(pt[0]);
          dy   <= 33'(pt[3]) - 33'(pt[1]);
          step <= '0;
        end
        ST_S, ST_T: begin
          if (step[1]) begin
            if (state == ST_S) sv <= acc[66:0];
            else tv <= acc[66:0];
            step <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_HY: xfs <= acc[63:0];
        ST_HXS: begin
          hx <= 32'(33'(q.start_x) + 33'(xfs >>> FRAC_BITS));
          hy <= 32'(33'(q.start_y) + 33'(acc >>> FRAC_BITS));
          step <= '0;
        end
        ST_D1, ST_D2: begin
          if (step[1]) begin
            step <= '0;
            if (state == ST_D2 && !(acc > 0)) begin
              rsp       <= '{hit: 1'b1, hit_x: hx, hit_y: hy, status: 1'b0};
              rsp_valid <= 1'b1;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_NEXT: idx <= idx + 1'b1;
        ST_RESP: if (rsp_ready) rsp_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  assign ram_raddr = idx[AW-1:0];
  assign dnum = sv;
  assign dden = sv - tv;

  // Checks.
  `SPSH_ASSERT_IMP(a_cnt_max, clk, rst, 1'b1, count <= CW'(MAX_SEGMENTS),
    "segment count above table size")
  `SPSH_ASSERT_IMP(a_ready_idle, clk, rst, req_ready, !rsp_valid,
    "request taken while a response is pending")
  `SPSH_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp),
    "response changed while stalled")
  `SPSH_ASSERT_NEXT(a_clear, clk, rst,
    req_valid && req_ready && req.req_type == REQ_CLEAR, count == '0,
    "clear did not empty table")

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Swept point segment hit testbench
// Drives add, query, clear and unused requests into the segment table block
// through several transform settings. A scoreboard predicts each response in
// exact wide integer arithmetic and compares it field by field with the block.
// ----------------------------------------------------------------------------
module testbench import spsh_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam longint ONE = 65536;
  localparam int STALL_LIMIT = 20000;

  typedef logic signed [127:0] acc_t;

  // Scoreboard: keeps its own copy of the table and the transform.
  class crossing_predictor;
    longint mat[6];
    longint seg[MAX_SEGMENTS_DEF][4];
    int count;
    rsp_t expected_rsp[$];
    int errors;

    function new();
      mat = '{ONE, 0, 0, ONE, 0, 0};
      count = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      mat[idx] = longint'($signed(val));
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Transformed coordinate: c selects the x row (0) or the y row (1).
    function longint xf(int c, longint x, longint y);
      longint p1, p2;
      p1 = (mat[2 * c] * x) >>> FRAC_BITS_DEF;
      p2 = (mat[2 * c + 1] * y) >>> FRAC_BITS_DEF;
      return sat(p1 + p2 + mat[CFG_TX + c]);
    endfunction

    // Works out the response to one accepted request and updates the table.
    function rsp_t predict(req_t r);
      rsp_t o;
      longint ax, ay, bx, by, dx, dy, sx, sy, ex, ey, px, py, ti;
      acc_t s, t, d1, d2;
      o = '0;
      case (r.req_type)
        REQ_ADD: begin
          if (count < MAX_SEGMENTS_DEF) begin
            seg[count] = '{r.seg_a_x, r.seg_a_y, r.seg_b_x, r.seg_b_y};
            count++;
          end else begin
            o.status = 1'b1;
          end
        end
        REQ_CLEAR: count = 0;
        REQ_QUERY: begin
          sx = r.start_x; sy = r.start_y; ex = r.end_x; ey = r.end_y;
          for (int j = 0; j < count; j++) begin
            ax = xf(0, seg[j][0], seg[j][1]);
            ay = xf(1, seg[j][0], seg[j][1]);
            bx = xf(0, seg[j][2], seg[j][3]);
            by = xf(1, seg[j][2], seg[j][3]);
            dx = bx - ax;
            dy = by - ay;
            s = acc_t'(dy) * acc_t'(sx - ax) - acc_t'(dx) * acc_t'(sy - ay);
            t = acc_t'(dy) * acc_t'(ex - ax) - acc_t'(dx) * acc_t'(ey - ay);
            if (!(s > 0) || t > 0) continue;
            ti = longint'((s <<< FRAC_BITS_DEF) / (s - t));
            px = sx + (((ex - sx) * ti) >>> FRAC_BITS_DEF);
            py = sy + (((ey - sy) * ti) >>> FRAC_BITS_DEF);
            d1 = acc_t'(dx) * acc_t'(px - ax) + acc_t'(dy) * acc_t'(py - ay);
            d2 = acc_t'(dx) * acc_t'(px - bx) + acc_t'(dy) * acc_t'(py - by);
            if (d1 < 0 || d2 > 0) continue;
            o.hit = 1'b1;
            o.hit_x = px[31:0];
            o.hit_y = py[31:0];
            break;
          end
        end
        default: ;
      endcase
      return o;
    endfunction

    function void note_request(req_t r);
      expected_rsp.push_back(predict(r));
    endfunction

    function void check_response(rsp_t a);
      rsp_t e;
      if (expected_rsp.size() == 0) begin
        $display("%0t: response with none outstanding: hit %0d x %0d y %0d status %0d",
                 $time, a.hit, a.hit_x, a.hit_y, a.status);
        errors++;
        return;
      end
      e = expected_rsp.pop_front();
      if (a.hit !== e.hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, e.hit, a.hit);
        errors++;
      end
      if (a.hit_x !== e.hit_x) begin
        $display("%0t: hit_x expected %0d actual %0d", $time, e.hit_x, a.hit_x);
        errors++;
      end
      if (a.hit_y !== e.hit_y) begin
        $display("%0t: hit_y expected %0d actual %0d", $time, e.hit_y, a.hit_y);
        errors++;
      end
      if (a.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_ready;
  rsp_t        rsp;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  crossing_predictor sb = new();
  bit no_idle = 1'b0;
  int hold_asked = 0;
  int hold_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int sent = 0;

  swept_point_segment_hit_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Handshake monitor feeding the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (req_valid && req_ready) sb.note_request(req);
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
    end
  end

  // Receiver: random back-pressure, with a long hold-off when the test asks for one.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (hold_done != hold_asked) begin
      hold_done <= hold_asked;
      hold_left <= 300;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= no_idle || ($urandom_range(99) >= 30);
    end
  end

  // Watchdog on cycles with no request or response moving.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request, with random idle cycles ahead of it.
  task automatic send(req_t r);
    while (!no_idle && $urandom_range(99) < 30) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent++;
  endtask

  // Lets every outstanding response arrive, then idles with no request offered.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[31:0];
    @(posedge clk);
  endtask

  task automatic set_matrix(longint xx, longint xy, longint yx, longint yy,
                            longint tx, longint ty);
    write_reg(CFG_XX, xx);
    write_reg(CFG_XY, xy);
    write_reg(CFG_YX, yx);
    write_reg(CFG_YY, yy);
    write_reg(CFG_TX, tx);
    write_reg(CFG_TY, ty);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic req_t noise_req(logic [1:0] kind);
    req_t r;
    logic [287:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
    r = noise[$bits(req_t)-1:0];
    r.req_type = kind;
    return r;
  endfunction

  function automatic req_t add_req(longint ax, longint ay, longint bx, longint by);
    req_t r;
    r = noise_req(REQ_ADD);
    r.seg_a_x = ax[31:0]; r.seg_a_y = ay[31:0];
    r.seg_b_x = bx[31:0]; r.seg_b_y = by[31:0];
    return r;
  endfunction

  function automatic req_t query_req(longint sx, longint sy, longint ex, longint ey);
    req_t r;
    r = noise_req(REQ_QUERY);
    r.start_x = sx[31:0]; r.start_y = sy[31:0];
    r.end_x = ex[31:0]; r.end_y = ey[31:0];
    return r;
  endfunction

  function automatic longint small_coord();
    return longint'($urandom_range(2 * 1048576)) - 1048576;
  endfunction

  // Query aimed across a stored segment, as seen through the transform.
  function automatic req_t aimed_query();
    int j;
    longint ax, ay, bx, by, mx, my, nx, ny, f;
    j = $urandom_range(sb.count - 1);
    ax = sb.xf(0, sb.seg[j][0], sb.seg[j][1]);
    ay = sb.xf(1, sb.seg[j][0], sb.seg[j][1]);
    bx = sb.xf(0, sb.seg[j][2], sb.seg[j][3]);
    by = sb.xf(1, sb.seg[j][2], sb.seg[j][3]);
    f = $urandom_range(280);
    mx = ax + ((bx - ax) * (f - 12)) / 256;
    my = ay + ((by - ay) * (f - 12)) / 256;
    nx = (by - ay) / longint'(2 + $urandom_range(14));
    ny = (ax - bx) / longint'(2 + $urandom_range(14));
    if ($urandom_range(9) == 0) return query_req(mx - nx, my - ny, mx + nx, my + ny);
    return query_req(mx + nx, my + ny, mx - nx / 2, my - ny / 2);
  endfunction

  function automatic req_t random_req();
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return noise_req(REQ_CLEAR);
    if (roll < 5) return noise_req(REQ_UNUSED);
    if (roll < 35) begin
      if (sb.count >= 12 && $urandom_range(3) == 0) return noise_req(REQ_CLEAR);
      if ($urandom_range(4) == 0) return noise_req(REQ_ADD);
      return add_req(small_coord(), small_coord(), small_coord(), small_coord());
    end
    if (sb.count > 0 && roll < 85) return aimed_query();
    if ($urandom_range(1) == 0) return noise_req(REQ_QUERY);
    return query_req(small_coord(), small_coord(), small_coord(), small_coord());
  endfunction

  task automatic random_phase(int n);
    repeat (n) send(random_req());
  endtask

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_XX;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the identity transform.
    set_matrix(ONE, 0, 0, ONE, 0, 0);
    send(noise_req(REQ_QUERY));                              // empty table
    send(add_req(0, -10 * ONE, 0, 10 * ONE));                // front side is +x
    send(query_req(5 * ONE, 0, -5 * ONE, 0));                // plain crossing
    send(query_req(-5 * ONE, 0, 5 * ONE, 0));                // start behind
    send(query_req(5 * ONE, 0, 2 * ONE, 3 * ONE));           // both in front
    send(query_req(5 * ONE, -ONE, 5 * ONE, ONE));            // parallel motion
    send(query_req(0, 0, -5 * ONE, 0));                      // start on the line
    send(query_req(5 * ONE, 10 * ONE, -5 * ONE, 10 * ONE));  // through endpoint B
    send(query_req(5 * ONE, 11 * ONE, -5 * ONE, 11 * ONE));  // past endpoint B
    send(query_req(5 * ONE, 3, -ONE, 3));                    // crosses, ends behind the line
    send(add_req(3 * ONE, 3 * ONE, 3 * ONE, 3 * ONE));       // zero length
    send(query_req(4 * ONE, 3 * ONE, 2 * ONE, 3 * ONE));
    send(add_req(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647));
    send(query_req(64'sd2147483647, -64'sd2147483648, -64'sd2147483648, 64'sd2147483647));
    send(query_req(-64'sd2147483648, 64'sd2147483647, 64'sd2147483647, -64'sd2147483648));
    send(noise_req(REQ_UNUSED));
    send(noise_req(REQ_CLEAR));
    send(query_req(5 * ONE, 0, -5 * ONE, 0));
    drain();

    // Fill the table past its end, then run aimed queries against it.
    repeat (MAX_SEGMENTS_DEF + 2)
      send(add_req(small_coord(), small_coord(), small_coord(), small_coord()));
    repeat (4) send(aimed_query());
    send(noise_req(REQ_CLEAR));
    drain();

    // Receiver holds off while the sender keeps offering short requests.
    hold_asked++;
    repeat (20) send(add_req(small_coord(), small_coord(), small_coord(), small_coord()));
    drain();
    send(noise_req(REQ_CLEAR));
    random_phase(120);
    drain();

    // Scaled, sheared and shifted transform.
    set_matrix(ONE / 2 + $urandom_range(ONE), $urandom_range(ONE / 2) - ONE / 4,
               $urandom_range(ONE / 2) - ONE / 4, ONE + $urandom_range(ONE),
               small_coord(), small_coord());
    random_phase(120);
    drain();

    // Extremes of every register, driving the transform into saturation.
    set_matrix(64'sd2147483647, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
               64'sd2147483647, -64'sd2147483648);
    random_phase(40);
    drain();
    set_matrix(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647,
               -64'sd2147483648, 64'sd2147483647);
    random_phase(40);
    drain();

    // Mirrored transform with no idling on either side.
    set_matrix(-ONE, 0, 0, ONE, ONE, -ONE);
    no_idle = 1'b1;
    random_phase(100);
    no_idle = 1'b0;
    drain();

    // Back to identity for the rest.
    set_matrix(ONE, 0, 0, ONE, 0, 0);
    while (sent < 600) send(random_req());
    drain();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- swept_point_segment_hit_unit.f -----
+incdir+hdl
hdl/spsh_pkg.sv
hdl/spsh_ram.sv
hdl/spsh_mac.sv
hdl/spsh_div.sv
hdl/swept_point_segment_hit_unit.sv
test/testbench.sv
